FILE: src/toroidal_tile_grid_store_core_macros.svh
// Assertion macros for the toroidal tile grid store.
// Define ASSERT_OFF to compile the checks away; no other dependencies.
`ifndef TOROIDAL_TILE_GRID_STORE_CORE_MACROS_SVH
`define TOROIDAL_TILE_GRID_STORE_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define TTGS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("toroidal tile grid store: assertion failed");
`define TTGS_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("toroidal tile grid store: reset assertion failed");
`else
`define TTGS_ASSERT(lbl, clk, rst_n, prop)
`define TTGS_ASSERT_RST(lbl, clk, prop)
`endif
`endif

FILE: src/ttgs_pkg.sv
// Shared constants and types of the toroidal tile grid store.
// No dependencies; imported by every module of the block.
package ttgs_pkg;

  localparam int DefMaxCols       = 256;
  localparam int DefMaxRows       = 256;
  localparam int DefObstacleSlots = 8;

  localparam int CoordW   = 10;
  localparam int DimW     = 9;
  localparam int TileW    = 8;
  localparam int CountW   = 17;
  localparam int CmdW     = 2;
  localparam int ObsCntW  = 4;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;

  localparam logic [CmdW-1:0] CmdRead  = 2'd0;
  localparam logic [CmdW-1:0] CmdWrite = 2'd1;
  localparam logic [CmdW-1:0] CmdQuery = 2'd2;
  localparam logic [CmdW-1:0] CmdCount = 2'd3;

  localparam logic [CfgIdxW-1:0] RegGridWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegGridHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGoneTile   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegObsEnabled = 3'd3;
  localparam logic [CfgIdxW-1:0] RegObsCount   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegObsCodes   = 3'd5;

  localparam logic [CountW-1:0] CountMax = '1;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_req_t;

endpackage

FILE: src/ttgs_wrap.sv
// One coordinate lane: signed value reduced by a true modulo of the span.
// Restoring remainder, one bit a cycle; uses ttgs_pkg.
module ttgs_wrap import ttgs_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [CoordW-1:0] coord_i,
  input  logic [DimW-1:0]          span_i,
  output logic [DimW-1:0]          wrapped_o,
  output logic                     done_o
);

  localparam int StepW = $clog2(CoordW);
  localparam logic [StepW-1:0] LastStep = StepW'(CoordW - 1);

  logic [CoordW-1:0] raw;
  logic [CoordW-1:0] mag_init;
  logic [CoordW-1:0] mag_q;
  logic              neg_q;
  logic [DimW-1:0]   span_q;
  logic [DimW-1:0]   rem_q, rem_d;
  logic [DimW-1:0]   res_q;
  logic [CoordW-1:0] trial;
  logic [CoordW-1:0] span_ext;
  logic [StepW-1:0]  step_q;
  logic              run_q, fix_q, done_q;

  assign raw      = coord_i;
  assign mag_init = raw[CoordW-1] ? (~raw + CoordW'(1)) : raw;
  assign trial    = {rem_q, mag_q[CoordW-1]};
  assign span_ext = CoordW'(span_q);
  assign rem_d    = (trial >= span_ext) ? DimW'(trial - span_ext) : trial[DimW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fix_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= fix_q;
      fix_q  <= run_q && (step_q == LastStep);
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        step_q <= step_q + StepW'(1);
        if (step_q == LastStep) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q  <= mag_init;
      neg_q  <= raw[CoordW-1];
      span_q <= span_i;
      rem_q  <= '0;
    end else if (run_q) begin
      mag_q <= {mag_q[CoordW-2:0], 1'b0};
      rem_q <= rem_d;
    end
    if (fix_q) begin
      res_q <= (neg_q && (rem_q != '0)) ? (span_q - rem_q) : rem_q;
    end
  end

  assign wrapped_o = res_q;
  assign done_o    = done_q;

endmodule

FILE: src/ttgs_store.sv
// Tile memory: one port, registered synchronous read.
// Sweeps every cell to zero after reset; uses ttgs_pkg.
module ttgs_store import ttgs_pkg::*; #(
  parameter int Depth = DefMaxCols * DefMaxRows,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mem_req_t         req_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [TileW-1:0] wdata_i,
  output logic [TileW-1:0] rdata_o,
  output logic             clearing_o
);

  logic [TileW-1:0] mem [Depth];
  logic [TileW-1:0] rdata_q;
  logic             clr_q;
  logic [AddrW-1:0] clr_addr_q;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [TileW-1:0] wr_data;

  assign wr_en   = clr_q || req_i.wr_en;
  assign wr_addr = clr_q ? clr_addr_q : addr_i;
  assign wr_data = clr_q ? '0 : wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + AddrW'(1);
      if (clr_addr_q == AddrW'(Depth - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (req_i.rd_en && !clr_q) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o    = rdata_q;
  assign clearing_o = clr_q;

endmodule

FILE: src/toroidal_tile_grid_store_core.sv
// Top level of the toroidal tile grid store: registers, sequencer, count walk.
// Uses ttgs_pkg, ttgs_wrap, ttgs_store and the assertion macro header.
//
//  channel   handshake          word
//  command   start / busy       cmd_i, col_i, row_i, tile_in_i
//  result    done_o (1 cycle)   tile_out_o, impassable_o, tile_count_o
//  config    cfg_we_i           cfg_idx_i, cfg_data_i
//
// Read, query and write wait on the ten-step remainder lanes; reads answer in S_RESP.
// Count walks each cell in use in turn through the one memory read port.
// After reset a clearing pass over all MAX_COLS * MAX_ROWS cells holds busy high.
// Config writes are taken in every cycle; results cannot be stalled.
`include "toroidal_tile_grid_store_core_macros.svh"
module toroidal_tile_grid_store_core import ttgs_pkg::*; #(
  parameter int MAX_COLS       = DefMaxCols,
  parameter int MAX_ROWS       = DefMaxRows,
  parameter int OBSTACLE_SLOTS = DefObstacleSlots
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [CfgDataW-1:0]      cfg_data_i,
  input  logic                     start,
  output logic                     busy,
  input  logic [CmdW-1:0]          cmd_i,
  input  logic signed [CoordW-1:0] col_i,
  input  logic signed [CoordW-1:0] row_i,
  input  logic [TileW-1:0]         tile_in_i,
  output logic                     done_o,
  output logic [TileW-1:0]         tile_out_o,
  output logic                     impassable_o,
  output logic [CountW-1:0]        tile_count_o
);

  localparam int Depth = MAX_COLS * MAX_ROWS;
  localparam int AddrW = $clog2(Depth);
  localparam int CellW = 2 * DimW;
  localparam int ProdW = CellW + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WRAP  = 3'd1;
  localparam logic [2:0] S_ACC   = 3'd2;
  localparam logic [2:0] S_RESP  = 3'd3;
  localparam logic [2:0] S_CNT   = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;

  logic [DimW-1:0]     width_q, height_q;
  logic [TileW-1:0]    gone_q;
  logic                obs_en_q;
  logic [ObsCntW-1:0]  obs_cnt_q;
  logic [CfgDataW-1:0] obs_codes_q;

  logic [2:0]          state_q, state_d;
  logic [CmdW-1:0]     cmd_q;
  logic [TileW-1:0]    tile_q;
  logic [AddrW-1:0]    addr_q;
  logic [CellW-1:0]    walk_q, last_q;
  logic [CountW-1:0]   cnt_q, cnt_next;
  logic                cnt_rd_q;
  logic                done_q, done_d;
  logic [TileW-1:0]    tout_q, tout_d;
  logic                imp_q, imp_d;
  logic [CountW-1:0]   tcnt_q, tcnt_d;

  logic [DimW-1:0]     wu, hu;
  logic [CellW-1:0]    cells;
  logic [ObsCntW-1:0]  obs_lim;
  logic                accept, wrap_start;
  logic [DimW-1:0]     col_w, row_w;
  logic                col_done, row_done;
  logic                clearing;
  mem_req_t            mem_req;
  logic [AddrW-1:0]    mem_addr;
  logic [TileW-1:0]    rd_data;
  logic                blocks;
  logic                hit, alive;
  logic [TileW-1:0]    code;

  assign wu = (width_q == '0) ? DimW'(1) :
              ((32'(width_q) > 32'(MAX_COLS)) ? DimW'(MAX_COLS) : width_q);
  assign hu = (height_q == '0) ? DimW'(1) :
              ((32'(height_q) > 32'(MAX_ROWS)) ? DimW'(MAX_ROWS) : height_q);
  assign cells   = CellW'(wu) * CellW'(hu);
  assign obs_lim = (obs_cnt_q > ObsCntW'(OBSTACLE_SLOTS)) ? ObsCntW'(OBSTACLE_SLOTS)
                                                          : obs_cnt_q;

  assign busy       = (state_q != S_IDLE) || clearing;
  assign accept     = start && !busy;
  assign wrap_start = accept && (cmd_i != CmdCount);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= DimW'(256);
      height_q    <= DimW'(256);
      gone_q      <= '0;
      obs_en_q    <= 1'b0;
      obs_cnt_q   <= '0;
      obs_codes_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegGridWidth:  width_q     <= cfg_data_i[DimW-1:0];
        RegGridHeight: height_q    <= cfg_data_i[DimW-1:0];
        RegGoneTile:   gone_q      <= cfg_data_i[TileW-1:0];
        RegObsEnabled: obs_en_q    <= cfg_data_i[0];
        RegObsCount:   obs_cnt_q   <= cfg_data_i[ObsCntW-1:0];
        RegObsCodes:   obs_codes_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ttgs_wrap u_col_wrap (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (wrap_start),
    .coord_i   (col_i),
    .span_i    (wu),
    .wrapped_o (col_w),
    .done_o    (col_done)
  );

  ttgs_wrap u_row_wrap (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (wrap_start),
    .coord_i   (row_i),
    .span_i    (hu),
    .wrapped_o (row_w),
    .done_o    (row_done)
  );

  ttgs_store #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (mem_req),
    .addr_i     (mem_addr),
    .wdata_i    (tile_q),
    .rdata_o    (rd_data),
    .clearing_o (clearing)
  );

  // stop the obstacle list at its first zero code
  always_comb begin
    hit   = 1'b0;
    alive = 1'b1;
    code  = '0;
    for (int k = 0; k < OBSTACLE_SLOTS; k++) begin
      code = obs_codes_q[TileW*k +: TileW];
      if (code == '0) begin
        alive = 1'b0;
      end
      if (alive && (ObsCntW'(k) < obs_lim) && (code == rd_data)) begin
        hit = 1'b1;
      end
    end
    blocks = (rd_data == gone_q) || (obs_en_q && ((rd_data == '0) || hit));
  end

  assign cnt_next = (cnt_rd_q && (rd_data == tile_q) && (cnt_q != CountMax))
                    ? cnt_q + CountW'(1) : cnt_q;

  always_comb begin
    state_d  = state_q;
    mem_req  = '0;
    mem_addr = addr_q;
    done_d   = 1'b0;
    tout_d   = '0;
    imp_d    = 1'b0;
    tcnt_d   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (cmd_i == CmdCount) ? S_CNT : S_WRAP;
        end
      end
      S_WRAP: begin
        if (col_done) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        if (cmd_q == CmdWrite) begin
          mem_req.wr_en = 1'b1;
          done_d        = 1'b1;
          state_d       = S_IDLE;
        end else begin
          mem_req.rd_en = 1'b1;
          state_d       = S_RESP;
        end
      end
      S_RESP: begin
        done_d  = 1'b1;
        tout_d  = rd_data;
        imp_d   = (cmd_q == CmdQuery) && blocks;
        state_d = S_IDLE;
      end
      S_CNT: begin
        mem_req.rd_en = 1'b1;
        mem_addr      = AddrW'(walk_q);
        if (walk_q == last_q) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        done_d  = 1'b1;
        tcnt_d  = cnt_next;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      done_q   <= 1'b0;
      cnt_rd_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      done_q   <= done_d;
      cnt_rd_q <= (state_q == S_CNT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_i;
      tile_q <= tile_in_i;
      walk_q <= '0;
      cnt_q  <= '0;
      last_q <= cells - CellW'(1);
    end
    if ((state_q == S_WRAP) && col_done) begin
      addr_q <= AddrW'(ProdW'(row_w) * ProdW'(wu) + ProdW'(col_w));
    end
    if (state_q == S_CNT) begin
      walk_q <= walk_q + CellW'(1);
      cnt_q  <= cnt_next;
    end
    if (done_d) begin
      tout_q <= tout_d;
      imp_q  <= imp_d;
      tcnt_q <= tcnt_d;
    end
  end

  assign done_o       = done_q;
  assign tile_out_o   = tout_q;
  assign impassable_o = imp_q;
  assign tile_count_o = tcnt_q;

  `TTGS_ASSERT(a_lanes_in_step, clk_i, rst_ni, col_done |-> row_done)
  `TTGS_ASSERT(a_result_source, clk_i, rst_ni, done_o |-> ($past(state_q) == S_RESP || $past(state_q) == S_DRAIN || ($past(state_q) == S_ACC && $past(cmd_q) == CmdWrite)))
  `TTGS_ASSERT(a_busy_in_clear, clk_i, rst_ni, clearing |-> busy)
  `TTGS_ASSERT_RST(a_idle_in_reset, clk_i, !rst_ni |-> (state_q == S_IDLE && !done_o))

endmodule

FILE: tb/tb_toroidal_tile_grid_store_core.sv
`timescale 1ns / 100ps
// Testbench for toroidal_tile_grid_store_core: a directed table, then random phases
// with changing grid size and obstacle setup; typed table rows are held to fixed
// answers, the rest to an in-bench grid model. Depends on ttgs_pkg and the core RTL only.
module tb_toroidal_tile_grid_store_core;
  import ttgs_pkg::*;

  typedef struct packed {
    logic [TileW-1:0]  tile;
    logic              imp;
    logic [CountW-1:0] count;
  } grid_reply_t;

  typedef struct packed {
    logic                is_cfg;
    logic [CfgIdxW-1:0]  reg_idx;
    logic [CfgDataW-1:0] cfg_val;
    logic [CmdW-1:0]     cmd;
    logic [CoordW-1:0]   col;
    logic [CoordW-1:0]   row;
    logic [TileW-1:0]    tile;
    logic                typed;
    logic [TileW-1:0]    x_tile;
    logic                x_imp;
    logic [CountW-1:0]   x_count;
  } plan_row_t;

  localparam int PlanRows = 34;
  localparam int Phases = 8;
  localparam int PhaseWords = 100;
  localparam int CountCellLimit = 1024;

  localparam plan_row_t PLAN [PlanRows] = '{
    '{1'b0, '0, '0, CmdRead,  10'h000, 10'h000, 8'h00, 1'b1, 8'h00, 1'b0, 17'd0},
    '{1'b0, '0, '0, CmdQuery, 10'h000, 10'h000, 8'h00, 1'b1, 8'h00, 1'b1, 17'd0},
    '{1'b0, '0, '0, CmdWrite, 10'h200, 10'h200, 8'hFF, 1'b1, 8'h00, 1'b0, 17'd0},
    '{1'b0, '0, '0, CmdRead,  10'h000, 10'h000, 8'h00, 1'b1, 8'hFF, 1'b0, 17'd0},
    '{1'b0, '0, '0, CmdWrite, 10'h1FF, 10'h1FF, 8'h5A, 1'b1, 8'h00, 1'b0, 17'd0},
    '{1'b0, '0, '0, CmdRead,  10'h3FF, 10'h3FF, 8'h00, 1'b1, 8'h5A, 1'b0, 17'd0},
    '{1'b0, '0, '0, CmdQuery, 10'h0FF, 10'h2FF, 8'h00, 1'b1, 8'h5A, 1'b0, 17'd0},
    '{1'b0, '0, '0, CmdCount, 10'h000, 10'h000, 8'h00, 1'b1, 8'h00, 1'b0, 17'd65534},
    '{1'b1, RegGridWidth,  64'd0, '0, '0, '0, '0, 1'b0, '0, 1'b0, '0},
    '{1'b1, RegGridHeight, 64'd0, '0, '0, '0, '0, 1'b0, '0, 1'b0, '0},
    '{1'b0, '0, '0, CmdRead,  10'h07B, 10'h3B3, 8'h00, 1'b1, 8'hFF, 1'b0, 17'd0},
    '{1'b0, '0, '0, CmdCount, 10'h000, 10'h000, 8'hFF, 1'b1, 8'h00, 1'b0, 17'd1},
    '{1'b1, RegGridWidth,  64'd511, '0, '0, '0, '0, 1'b0, '0, 1'b0, '0},
    '{1'b1, RegGridHeight, 64'd2,   '0, '0, '0, '0, 1'b0, '0, 1'b0, '0},
    '{1'b0, '0, '0, CmdWrite, 10'h3FF, 10'h001, 8'h33, 1'b1, 8'h00, 1'b0, 17'd0},
    '{1'b0, '0, '0, CmdCount, 10'h000, 10'h000, 8'h5A, 1'b0, '0, 1'b0, '0},
    '{1'b0, '0, '0, CmdRead,  10'h0FF, 10'h3FF, 8'h00, 1'b0, '0, 1'b0, '0},
    '{1'b1, RegGoneTile,   64'hFF, '0, '0, '0, '0, 1'b0, '0, 1'b0, '0},
    '{1'b1, RegObsEnabled, 64'd1,  '0, '0, '0, '0, 1'b0, '0, 1'b0, '0},
    '{1'b1, RegObsCount,   64'd15, '0, '0, '0, '0, 1'b0, '0, 1'b0, '0},
    '{1'b1, RegObsCodes, 64'h0000_0033_0044_5566, '0, '0, '0, '0, 1'b0, '0, 1'b0, '0},
    '{1'b0, '0, '0, CmdQuery, 10'h000, 10'h000, 8'h00, 1'b0, '0, 1'b0, '0},
    '{1'b0, '0, '0, CmdQuery, 10'h3FF, 10'h001, 8'h00, 1'b0, '0, 1'b0, '0},
    '{1'b0, '0, '0, CmdQuery, 10'h001, 10'h000, 8'h00, 1'b0, '0, 1'b0, '0},
    '{1'b0, '0, '0, CmdWrite, 10'h002, 10'h000, 8'h44, 1'b0, '0, 1'b0, '0},
    '{1'b0, '0, '0, CmdQuery, 10'h002, 10'h000, 8'h00, 1'b0, '0, 1'b0, '0},
    '{1'b0, '0, '0, CmdWrite, 10'h003, 10'h000, 8'h66, 1'b0, '0, 1'b0, '0},
    '{1'b0, '0, '0, CmdQuery, 10'h003, 10'h000, 8'h00, 1'b0, '0, 1'b0, '0},
    '{1'b1, RegObsCount,   64'd0, '0, '0, '0, '0, 1'b0, '0, 1'b0, '0},
    '{1'b0, '0, '0, CmdQuery, 10'h002, 10'h000, 8'h00, 1'b0, '0, 1'b0, '0},
    '{1'b0, '0, '0, CmdQuery, 10'h001, 10'h000, 8'h00, 1'b0, '0, 1'b0, '0},
    '{1'b1, RegObsEnabled, 64'd0, '0, '0, '0, '0, 1'b0, '0, 1'b0, '0},
    '{1'b0, '0, '0, CmdQuery, 10'h001, 10'h000, 8'h00, 1'b0, '0, 1'b0, '0},
    '{1'b0, '0, '0, CmdCount, 10'h000, 10'h000, 8'h00, 1'b0, '0, 1'b0, '0}
  };

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b1;
  logic                     cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]       cfg_idx_i = '0;
  logic [CfgDataW-1:0]      cfg_data_i = '0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [CmdW-1:0]          cmd_i = CmdRead;
  logic signed [CoordW-1:0] col_i = '0;
  logic signed [CoordW-1:0] row_i = '0;
  logic [TileW-1:0]         tile_in_i = '0;
  logic                     done_o;
  logic [TileW-1:0]         tile_out_o;
  logic                     impassable_o;
  logic [CountW-1:0]        tile_count_o;

  logic [TileW-1:0]    grid_cells [DefMaxCols * DefMaxRows];
  logic [DimW-1:0]     grid_w;
  logic [DimW-1:0]     grid_h;
  logic [TileW-1:0]    gone_code;
  logic                obs_on;
  logic [ObsCntW-1:0]  obs_num;
  logic [CfgDataW-1:0] obs_list;

  grid_reply_t grid_replies [$];
  int err_cnt = 0;
  int gap_pct = 0;

  toroidal_tile_grid_store_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .start        (start),
    .busy         (busy),
    .cmd_i        (cmd_i),
    .col_i        (col_i),
    .row_i        (row_i),
    .tile_in_i    (tile_in_i),
    .done_o       (done_o),
    .tile_out_o   (tile_out_o),
    .impassable_o (impassable_o),
    .tile_count_o (tile_count_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic int used_span(input logic [DimW-1:0] v, input int lim);
    if (v == 0) return 1;
    if (int'(v) > lim) return lim;
    return int'(v);
  endfunction

  function automatic int wrap_axis(input logic [CoordW-1:0] raw, input int span);
    int v;
    int r;
    v = $signed(raw);
    r = v % span;
    if (r < 0) r += span;
    return r;
  endfunction

  function automatic logic tile_blocks(input logic [TileW-1:0] t);
    int n;
    logic [TileW-1:0] code;
    if (t == gone_code) return 1'b1;
    if (!obs_on) return 1'b0;
    if (t == 0) return 1'b1;
    n = (obs_num > DefObstacleSlots) ? DefObstacleSlots : int'(obs_num);
    for (int k = 0; k < n; k++) begin
      code = obs_list[8*k +: 8];
      if (code == 0) break;
      if (code == t) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic grid_reply_t grid_answer(input logic [CmdW-1:0] c,
      input logic [CoordW-1:0] x, input logic [CoordW-1:0] y, input logic [TileW-1:0] t);
    grid_reply_t ans;
    int w;
    int h;
    int addr;
    int cells;
    logic [CountW-1:0] n;
    ans = '0;
    w = used_span(grid_w, DefMaxCols);
    h = used_span(grid_h, DefMaxRows);
    addr = wrap_axis(y, h) * w + wrap_axis(x, w);
    case (c)
      CmdRead: ans.tile = grid_cells[addr];
      CmdWrite: grid_cells[addr] = t;
      CmdQuery: begin
        ans.tile = grid_cells[addr];
        ans.imp = tile_blocks(ans.tile);
      end
      default: begin
        cells = w * h;
        n = '0;
        for (int i = 0; i < cells; i++) begin
          if (grid_cells[i] == t && n != CountMax) n++;
        end
        ans.count = n;
      end
    endcase
    return ans;
  endfunction

  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      RegGridWidth: grid_w = val[DimW-1:0];
      RegGridHeight: grid_h = val[DimW-1:0];
      RegGoneTile: gone_code = val[TileW-1:0];
      RegObsEnabled: obs_on = val[0];
      RegObsCount: obs_num = val[ObsCntW-1:0];
      RegObsCodes: obs_list = val;
      default: ;
    endcase
  endtask

  task automatic settle();
    @(negedge clk_i);
    start = 1'b0;
    while (grid_replies.size() != 0 || busy) @(posedge clk_i);
  endtask

  task automatic issue_word(input logic [CmdW-1:0] c, input logic [CoordW-1:0] x,
      input logic [CoordW-1:0] y, input logic [TileW-1:0] t, input logic typed,
      input grid_reply_t fixed);
    grid_reply_t want;
    int gap;
    gap = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 20) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_i = c;
    col_i = x;
    row_i = y;
    tile_in_i = t;
    start = 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    want = grid_answer(c, x, y, t);
    if (typed) want = fixed;
    grid_replies.push_back(want);
  endtask

  function automatic logic [TileW-1:0] pick_tile();
    case ($urandom_range(0, 3))
      0: return obs_list[8*$urandom_range(0, 7) +: 8];
      1: return gone_code;
      2: return TileW'($urandom_range(0, 3));
      default: return TileW'($urandom());
    endcase
  endfunction

  task automatic setup_phase(input int ph);
    logic [DimW-1:0] w;
    logic [DimW-1:0] h;
    logic [CfgDataW-1:0] noise;
    logic [CfgDataW-1:0] codes;
    case (ph)
      0: begin w = DimW'(256); h = DimW'(1); end
      1: begin w = DimW'(1); h = DimW'(256); end
      2: begin w = '0; h = '0; end
      3: begin w = DimW'(256); h = DimW'(256); end
      4: begin w = DimW'($urandom_range(257, 511)); h = '0; end
      default: begin
        w = DimW'($urandom_range(1, 24));
        h = DimW'($urandom_range(1, 24));
      end
    endcase
    noise = {$urandom(), $urandom()};
    put_reg(RegGridWidth, {noise[CfgDataW-1:DimW], w});
    noise = {$urandom(), $urandom()};
    put_reg(RegGridHeight, {noise[CfgDataW-1:DimW], h});
    noise = {$urandom(), $urandom()};
    put_reg(RegGoneTile, noise);
    noise = {$urandom(), $urandom()};
    put_reg(RegObsEnabled, noise);
    noise = {$urandom(), $urandom()};
    put_reg(RegObsCount, noise);
    for (int k = 0; k < 8; k++) begin
      codes[8*k +: 8] = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
    end
    put_reg(RegObsCodes, codes);
  endtask

  always @(posedge clk_i) begin : check_reply
    grid_reply_t want;
    if (rst_ni && done_o) begin
      if (grid_replies.size() == 0) begin
        $error("result word with nothing expected");
        err_cnt++;
      end else begin
        want = grid_replies.pop_front();
        if (tile_out_o !== want.tile) begin
          $error("tile_out: expected %0h, got %0h", want.tile, tile_out_o);
          err_cnt++;
        end
        if (impassable_o !== want.imp) begin
          $error("impassable: expected %0b, got %0b", want.imp, impassable_o);
          err_cnt++;
        end
        if (tile_count_o !== want.count) begin
          $error("tile_count: expected %0d, got %0d", want.count, tile_count_o);
          err_cnt++;
        end
      end
    end
  end

  initial begin : stimulus
    plan_row_t r;
    logic [CmdW-1:0] c;
    int roll;
    grid_w = DimW'(256);
    grid_h = DimW'(256);
    gone_code = '0;
    obs_on = 1'b0;
    obs_num = '0;
    obs_list = '0;
    for (int i = 0; i < DefMaxCols * DefMaxRows; i++) grid_cells[i] = '0;
    #1 rst_ni = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    gap_pct = 28;
    for (int k = 0; k < PlanRows; k++) begin
      r = PLAN[k];
      if (r.is_cfg) begin
        settle();
        put_reg(r.reg_idx, r.cfg_val);
      end else begin
        issue_word(r.cmd, r.col, r.row, r.tile, r.typed, {r.x_tile, r.x_imp, r.x_count});
      end
    end

    for (int ph = 0; ph < Phases; ph++) begin
      settle();
      setup_phase(ph);
      gap_pct = (ph < 3) ? 28 : (ph < 6) ? 64 : 0;
      for (int n = 0; n < PhaseWords; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 35) c = CmdWrite;
        else if (roll < 55) c = CmdRead;
        else if (roll < 78) c = CmdQuery;
        else c = CmdCount;
        if (c == CmdCount && used_span(grid_w, DefMaxCols) * used_span(grid_h, DefMaxRows)
            > CountCellLimit) c = CmdQuery;
        if ($urandom_range(0, 99) < 2) settle();
        issue_word(c, CoordW'($urandom()), CoordW'($urandom()), pick_tile(), 1'b0, '0);
      end
    end

    settle();
    repeat (40) @(posedge clk_i);
    if (err_cnt == 0 && grid_replies.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #(20_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule
